/* sv/windowed_rsi_top_defines.svh */
// assertion macros for the windowed rsi block
`ifndef WINDOWED_RSI_TOP_DEFINES_SVH
`define WINDOWED_RSI_TOP_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define WRSI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define WRSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wrsi_pkg.sv */
// constants shared by the windowed rsi block
package wrsi_pkg;

    localparam int MAX_WINDOW_DEF = 256;
    localparam int PRICE_BITS_DEF = 32;

    localparam int IN_BITS    = 32;
    localparam int WIN_BITS   = 9;
    localparam int FLOOR_BITS = 20;
    localparam int RSI_BITS   = 14;
    localparam int CFG_BITS   = 32;
    localparam int ADDR_BITS  = 3;

    localparam logic [WIN_BITS-1:0]   WIN_RESET   = 9'd21;
    localparam logic [FLOOR_BITS-1:0] FLOOR_RESET = 20'd1;
    localparam logic [RSI_BITS-1:0]   RSI_SCALE   = 14'd10000;

    // register index, taken from the word address
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_FLOOR  = 1'b1;

endpackage

/* sv/windowed_rsi_top.sv */
// windowed rsi: sliding-window relative strength index with a ring memory of deltas
//
//  channel   dir   handshake                    payload
//  s_axis    in    s_axis_tvalid/tready         tdata = close_price
//  m_axis    out   m_axis_tvalid/tready         tdata = rsi_hundredths, tuser = rsi_valid
//  apb       in    psel/penable/pwrite/pready   window_length @0x0, zero_down_floor @0x4
//
//  when a ratio is formed, a word passes from accept through the ring read-modify-write,
//  scaling and 14 restoring divider steps to delivery before the next accept; words
//  before the window fills skip the scaling and divider steps.
//  synchronous active-low reset; the ring needs no clearing pass, entries are read
//  only after the history count shows they were written since the last clear.
//  a new word is accepted while the previous result still waits in the output register;
//  delivery of the next result waits only until that register is taken.
`include "windowed_rsi_top_defines.svh"

module windowed_rsi_top #(
    parameter int MAX_WINDOW = wrsi_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = wrsi_pkg::PRICE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // stream in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [wrsi_pkg::IN_BITS-1:0]   s_axis_tdata,   // [31:0] close_price
    // stream out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,   // [13:0] rsi_hundredths, [15:14] 0
    output logic [0:0]                     m_axis_tuser,   // [0] rsi_valid
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wrsi_pkg::ADDR_BITS-1:0] paddr,
    input  logic [wrsi_pkg::CFG_BITS-1:0]  pwdata,
    output logic [wrsi_pkg::CFG_BITS-1:0]  prdata,
    output logic                           pready
);
    import wrsi_pkg::*;

    // price bits actually used, never more than the input field
    localparam int P_BITS   = (PRICE_BITS < IN_BITS) ? PRICE_BITS : IN_BITS;
    localparam int D_BITS   = P_BITS + 1;
    localparam int PTR_BITS = $clog2(MAX_WINDOW);
    localparam int CNT_BITS = $clog2(MAX_WINDOW + 2);
    localparam int SUM_BITS = P_BITS + PTR_BITS;
    localparam int TOT_BITS = ((SUM_BITS > FLOOR_BITS) ? SUM_BITS : FLOOR_BITS) + 1;
    localparam int NUM_BITS = TOT_BITS + RSI_BITS;
    localparam int STEP_BITS = $clog2(RSI_BITS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UPD  = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [WIN_BITS-1:0]   r_win;
    logic [FLOOR_BITS-1:0] r_floor;

    // history
    logic [P_BITS-1:0]   r_prev, n_prev;
    logic [P_BITS-1:0]   r_price;
    logic [PTR_BITS-1:0] r_ptr, n_ptr;
    logic [CNT_BITS-1:0] r_items, n_items;
    logic [SUM_BITS-1:0] r_rise, n_rise;
    logic [SUM_BITS-1:0] r_fall, n_fall;

    // delta ring memory, one read and one write port
    logic [D_BITS-1:0]   mem_ring [MAX_WINDOW];
    logic [D_BITS-1:0]   r_rd;
    logic                mem_we;

    // divider datapath
    logic [NUM_BITS-1:0]  r_num;
    logic [NUM_BITS-1:0]  r_div;
    logic [RSI_BITS-1:0]  r_q;
    logic [STEP_BITS-1:0] r_step;
    logic                 r_zero_tot;
    logic                 r_res_valid;

    // output register
    logic                 r_out_valid;
    logic [RSI_BITS-1:0]  r_out_rsi;
    logic                 r_out_flag;

    logic                 in_acc;
    logic                 cfg_wr;
    logic                 win_wr;
    logic                 out_load;
    logic [CNT_BITS-1:0]  w_eff;
    logic [PTR_BITS-1:0]  ptr_eff;
    logic [D_BITS-1:0]    delta;
    logic [P_BITS-1:0]    d_pos, d_neg, o_pos, o_neg;
    logic                 full_win;
    logic [TOT_BITS-1:0]  dn_sum, total;
    logic                 div_ge;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign win_wr   = cfg_wr && (paddr[2] == REG_WINDOW);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    // window clamped to 1..MAX_WINDOW
    always_comb begin
        if (r_win == '0) begin
            w_eff = CNT_BITS'(1);
        end else if (32'(r_win) > 32'(MAX_WINDOW)) begin
            w_eff = CNT_BITS'(MAX_WINDOW);
        end else begin
            w_eff = CNT_BITS'(r_win);
        end
    end

    assign ptr_eff = (CNT_BITS'(r_ptr) >= w_eff) ? '0 : r_ptr;

    // new delta and the split of new and leaving deltas into rise and fall parts
    assign delta = {1'b0, r_price} - {1'b0, r_prev};
    assign d_pos = (!delta[D_BITS-1] && (delta != '0)) ? delta[P_BITS-1:0] : '0;
    assign d_neg = delta[D_BITS-1] ? P_BITS'(-delta) : '0;
    assign o_pos = (!r_rd[D_BITS-1] && (r_rd != '0)) ? r_rd[P_BITS-1:0] : '0;
    assign o_neg = r_rd[D_BITS-1] ? P_BITS'(-r_rd) : '0;

    // oldest delta leaves the sums once the window is full
    assign full_win = (r_items > w_eff);

    always_comb begin
        n_prev  = r_prev;
        n_ptr   = r_ptr;
        n_items = r_items;
        n_rise  = r_rise;
        n_fall  = r_fall;
        mem_we  = 1'b0;
        if ((r_state == S_UPD) && (r_items == '0)) begin
            // first price only primes the previous close
            n_items = CNT_BITS'(1);
            n_prev  = r_price;
        end else if (r_state == S_UPD) begin
            mem_we = 1'b1;
            n_prev = r_price;
            n_rise = r_rise - (full_win ? SUM_BITS'(o_pos) : '0) + SUM_BITS'(d_pos);
            n_fall = r_fall - (full_win ? SUM_BITS'(o_neg) : '0) + SUM_BITS'(d_neg);
            n_ptr  = ((CNT_BITS'(ptr_eff) + CNT_BITS'(1)) >= w_eff) ? '0 : ptr_eff + 1'b1;
            if (!full_win) begin
                n_items = r_items + 1'b1;
            end
        end
        if (win_wr) begin
            // new window length drops the whole history
            n_prev  = '0;
            n_ptr   = '0;
            n_items = '0;
            n_rise  = '0;
            n_fall  = '0;
        end
    end

    // down sum falls back to the floor register when nothing fell
    assign dn_sum = (r_fall == '0) ? TOT_BITS'(r_floor) : TOT_BITS'(r_fall);
    assign total  = TOT_BITS'(r_rise) + dn_sum;
    assign div_ge = (r_num >= r_div);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_UPD;
            S_UPD:   n_state = (n_items > w_eff) ? S_MUL : S_OUT;
            S_MUL:   n_state = S_DIV;
            S_DIV:   if (r_step == '0) n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win       <= WIN_RESET;
            r_floor     <= FLOOR_RESET;
            r_prev      <= '0;
            r_ptr       <= '0;
            r_items     <= '0;
            r_rise      <= '0;
            r_fall      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prev  <= n_prev;
            r_ptr   <= n_ptr;
            r_items <= n_items;
            r_rise  <= n_rise;
            r_fall  <= n_fall;
            if (win_wr) begin
                r_win <= pwdata[WIN_BITS-1:0];
            end
            if (cfg_wr && (paddr[2] == REG_FLOOR)) begin
                r_floor <= pwdata[FLOOR_BITS-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ring memory: registered read at the current slot, write back of the new delta
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_ring[ptr_eff] <= delta;
        end
        r_rd <= mem_ring[ptr_eff];
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_price <= s_axis_tdata[P_BITS-1:0];
        end
        case (r_state)
            S_UPD: begin
                r_q         <= '0;
                r_res_valid <= (n_items > w_eff);
            end
            S_MUL: begin
                r_num      <= NUM_BITS'(r_rise) * NUM_BITS'(RSI_SCALE);
                r_div      <= NUM_BITS'({total, {(RSI_BITS-1){1'b0}}});
                r_zero_tot <= (total == '0);
                r_step     <= STEP_BITS'(RSI_BITS - 1);
            end
            S_DIV: begin
                // one quotient bit per cycle
                if (div_ge) begin
                    r_num <= r_num - r_div;
                end
                r_q    <= {r_q[RSI_BITS-2:0], div_ge};
                r_div  <= r_div >> 1;
                r_step <= r_step - 1'b1;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_rsi  <= (r_res_valid && !r_zero_tot) ? r_q : '0;
            r_out_flag <= r_res_valid;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_rsi};
    assign m_axis_tuser  = r_out_flag;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FLOOR) ? CFG_BITS'(r_floor) : CFG_BITS'(r_win);

    // checks
    `WRSI_ASSERT_NEXT(a_one_word, in_acc, !s_axis_tready, "second word taken while busy")
    `WRSI_ASSERT_NEXT(a_win_clear, win_wr, r_items == '0, "history kept after window write")
    `WRSI_ASSERT_SAME(a_invalid_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "invalid result not zero")
    `WRSI_ASSERT_SAME(a_rsi_range, m_axis_tvalid, m_axis_tdata <= 16'(RSI_SCALE), "rsi above full scale")

endmodule

/* dv/windowed_rsi_top_tb.sv */
// self-checking testbench for the windowed rsi block: stream stimulus, apb setup, scoreboard
module windowed_rsi_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wrsi_pkg::*;

    // run ends here no matter what; a correct run needs a small fraction of it
    localparam int CYCLE_LIMIT = 400000;
    // settling time after the last expected word, covering anything still in flight
    localparam int SETTLE_CYCLES = 40;
    localparam int RING_DEPTH = MAX_WINDOW_DEF;

    localparam logic [ADDR_BITS-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
    localparam logic [ADDR_BITS-1:0] ADDR_FLOOR  = {REG_FLOOR, 2'b00};

    localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;

    // how the receiver throttles the output stream
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_SPARSE,
        STALL_BURSTY
    } stall_mode_e;

    // how the price walk moves during a phase
    typedef enum logic [1:0] {
        WALK_MIXED,
        WALK_RISING,
        WALK_FLAT
    } walk_mode_e;

    typedef struct packed {
        logic [RSI_BITS-1:0] rsi_hundredths;
        logic                rsi_valid;
    } rsi_word_t;

    // ------------------------------------------------------------------
    // dut signals
    // ------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_BITS-1:0]   s_axis_tdata;    // [31:0] close_price
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [15:0]          m_axis_tdata;    // [13:0] rsi_hundredths, [15:14] zero
    logic [0:0]           m_axis_tuser;    // [0] rsi_valid
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [CFG_BITS-1:0]  pwdata;
    logic [CFG_BITS-1:0]  prdata;
    logic                 pready;

    windowed_rsi_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------
    // predictor state: a private copy of the block's registers and history
    // ------------------------------------------------------------------
    logic [WIN_BITS-1:0]   window_reg;
    logic [FLOOR_BITS-1:0] floor_reg;
    logic [31:0]           last_close;
    logic signed [63:0]    delta_hist [RING_DEPTH];
    int unsigned           hist_ptr;
    int unsigned           hist_count;
    logic [63:0]           gain_sum;
    logic [63:0]           loss_sum;

    // expected outputs, oldest first
    rsi_word_t expected_rsi_q [$];

    int          error_count;
    int unsigned cycle_count;

    // sender burst shaping and price walk memory
    int unsigned burst_left;
    logic [31:0] walk_price;

    // ------------------------------------------------------------------
    // clock, timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs on a handshake
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void clear_history();
        hist_ptr   = 0;
        hist_count = 0;
        gain_sum   = '0;
        loss_sum   = '0;
        last_close = '0;
        foreach (delta_hist[k]) delta_hist[k] = '0;
    endfunction

    // advance the history by one close and queue the word the block must return
    function automatic void predict_rsi(input logic [31:0] price);
        int unsigned        win;
        logic signed [63:0] delta;
        logic signed [63:0] oldest;
        logic [63:0]        loss_used;
        logic [63:0]        total;
        rsi_word_t          word;

        // zero acts as one, anything past the ring depth acts as the depth
        if (window_reg == 0) begin
            win = 1;
        end else if (window_reg > RING_DEPTH) begin
            win = RING_DEPTH;
        end else begin
            win = window_reg;
        end
        if (hist_ptr >= win) hist_ptr = 0;

        if (hist_count == 0) begin
            // first close after a clear only primes the previous price
            hist_count = 1;
        end else begin
            delta = $signed({32'd0, price}) - $signed({32'd0, last_close});
            if (hist_count > win) begin
                // window full: retire the oldest delta from its sum
                oldest = delta_hist[hist_ptr];
                if (oldest > 0) begin
                    gain_sum = gain_sum - oldest;
                end else begin
                    loss_sum = loss_sum + oldest;
                end
            end
            delta_hist[hist_ptr] = delta;
            if (delta > 0) begin
                gain_sum = gain_sum + delta;
            end else begin
                loss_sum = loss_sum - delta;
            end
            hist_ptr = (hist_ptr + 1 >= win) ? 0 : hist_ptr + 1;
            if (hist_count <= win) hist_count++;
        end
        last_close = price;

        word = '0;
        if (hist_count > win) begin
            // no falling delta in the window: the floor register stands in
            loss_used = (loss_sum == 0) ? 64'(floor_reg) : loss_sum;
            total = gain_sum + loss_used;
            word.rsi_valid = 1'b1;
            if (total == 0) begin
                word.rsi_hundredths = '0;
            end else if (gain_sum >= total) begin
                word.rsi_hundredths = RSI_SCALE;
            end else begin
                word.rsi_hundredths = RSI_BITS'((gain_sum * 64'd10000) / total);
            end
        end
        expected_rsi_q.push_back(word);
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // one close on the input stream; bursts of random length, random gaps between
    task automatic send_close(input logic [31:0] price);
        int unsigned gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= price;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_rsi(price);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            // now and then a long stretch without any idle cycle
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 12);
        end
    endtask

    // let every queued result come back, then wait out anything still in flight
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_rsi_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // next close of a random walk; mostly small steps, some jumps and extremes
    function automatic logic [31:0] next_close(input walk_mode_e mode);
        int unsigned   pick;
        int unsigned   span;
        logic [32:0]   step;
        logic [32:0]   moved;
        logic          up;

        pick = $urandom_range(0, 99);
        if (mode == WALK_FLAT && pick < 60) return walk_price;
        if (pick < 75) begin
            span = $urandom_range(0, 24);
            step = 33'($urandom) & ((33'd1 << span) - 33'd1);
            up = (mode == WALK_RISING) ? ($urandom_range(0, 99) < 90)
                                       : ($urandom_range(0, 1) == 1);
            if (up) begin
                moved = {1'b0, walk_price} + step;
                walk_price = moved[32] ? PRICE_MAX : moved[31:0];
            end else begin
                walk_price = (step[31:0] > walk_price) ? 32'd0 : walk_price - step[31:0];
            end
        end else if (pick < 85) begin
            // no movement: a zero delta
        end else if (pick < 95) begin
            walk_price = $urandom;
        end else begin
            walk_price = $urandom_range(0, 1) ? PRICE_MAX : 32'd0;
        end
        return walk_price;
    endfunction

    task automatic run_walk(input int unsigned count, input walk_mode_e mode);
        repeat (count) send_close(next_close(mode));
    endtask

    // ------------------------------------------------------------------
    // configuration side
    // ------------------------------------------------------------------
    // apb write: setup cycle, access cycle, completes on pready
    task automatic write_register(input logic [ADDR_BITS-1:0] addr, input logic [31:0] value);
        drain_results();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_WINDOW) begin
            // a window write restarts the history
            window_reg = value[WIN_BITS-1:0];
            clear_history();
        end else if (addr == ADDR_FLOOR) begin
            floor_reg = value[FLOOR_BITS-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
    endtask

    // ------------------------------------------------------------------
    // output side: receiver stall pattern and scoreboard
    // ------------------------------------------------------------------
    initial begin
        stall_mode_e mode;
        int unsigned stretch;
        int unsigned phase;
        forever begin
            mode = stall_mode_e'($urandom_range(0, 3));
            stretch = $urandom_range(30, 150);
            phase = 0;
            repeat (stretch) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:   m_axis_tready <= 1'b1;
                    STALL_RANDOM: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    STALL_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:      m_axis_tready <= ((phase % 11) < 4);
                endcase
                phase++;
            end
        end
    end

    // compare each delivered word with the oldest prediction
    always @(posedge i_clk) begin
        rsi_word_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_rsi_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual rsi %0d valid %0d",
                         $time, m_axis_tdata, m_axis_tuser[0]);
                error_count++;
            end else begin
                want = expected_rsi_q.pop_front();
                if (m_axis_tdata != {2'b00, want.rsi_hundredths}) begin
                    $display("%0t: rsi_hundredths mismatch, expected %0d actual %0d",
                             $time, want.rsi_hundredths, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser[0] != want.rsi_valid) begin
                    $display("%0t: rsi_valid mismatch, expected %0d actual %0d",
                             $time, want.rsi_valid, m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset window of 21 and floor of 1: a rising run up to full scale fills the
    // window with no fall, so the floor substitutes; then a fall of full scale
    task automatic test_reset_setting();
        send_close(32'd0);
        for (int k = 1; k <= 20; k++) send_close(32'(k) * 32'd200_000_000);
        send_close(PRICE_MAX);
        send_close(32'd0);
    endtask

    // window 0 behaves as 1; floor 0 with no movement gives a zero total
    task automatic test_window_zero_and_zero_total();
        write_register(ADDR_WINDOW, 32'd0);
        write_register(ADDR_FLOOR, 32'd0);
        send_close(32'd5);
        send_close(32'd5);
        send_close(PRICE_MAX);
        send_close(32'd0);
    endtask

    // a floor write keeps the history; the floor at its top value
    task automatic test_floor_keeps_history();
        write_register(ADDR_FLOOR, 32'd1_000_000);
        send_close(32'd0);
        send_close(32'd1_000_000);
        write_register(ADDR_FLOOR, 32'h000F_FFFF);
        send_close(32'd1_000_000);
    endtask

    // short windows with various floors, some phases keep the history across a floor write
    task automatic test_short_windows();
        write_register(ADDR_WINDOW, 32'd2);
        run_walk(60, WALK_MIXED);
        write_register(ADDR_WINDOW, 32'd1);
        write_register(ADDR_FLOOR, 32'd1);
        run_walk(40, WALK_RISING);
        write_register(ADDR_WINDOW, 32'd21);
        run_walk(60, WALK_MIXED);
        write_register(ADDR_WINDOW, 32'd7);
        write_register(ADDR_FLOOR, 32'd0);
        run_walk(60, WALK_FLAT);
        write_register(ADDR_FLOOR, 32'($urandom_range(1, 1_000_000)));
        run_walk(40, WALK_RISING);
        write_register(ADDR_WINDOW, 32'($urandom_range(3, 12)));
        write_register(ADDR_FLOOR, 32'($urandom_range(0, 1_000_000)));
        run_walk(40, WALK_MIXED);
    endtask

    // full ring depth: the window wraps once the ring is full
    task automatic test_full_window();
        write_register(ADDR_WINDOW, 32'(RING_DEPTH));
        write_register(ADDR_FLOOR, 32'd1_000_000);
        run_walk(200, WALK_MIXED);
        run_walk(80, WALK_RISING);
    endtask

    // a window past the ring depth acts as the depth; also the top register value
    task automatic test_window_above_depth();
        write_register(ADDR_WINDOW, 32'd300);
        write_register(ADDR_FLOOR, 32'd5);
        run_walk(20, WALK_MIXED);
        write_register(ADDR_WINDOW, 32'hFFFF_FFFF);
        run_walk(20, WALK_MIXED);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        burst_left    = 0;
        walk_price    = 32'd50_000_000;
        window_reg    = WIN_RESET;
        floor_reg     = FLOOR_RESET;
        clear_history();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_setting();
        test_window_zero_and_zero_total();
        test_floor_keeps_history();
        test_short_windows();
        test_full_window();
        test_window_above_depth();

        drain_results();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/wrsi_pkg.sv
sv/windowed_rsi_top.sv
dv/windowed_rsi_top_tb.sv
